FILE: rtl/tlst_pkg.sv
`default_nettype none
package tlst_pkg;

    localparam int COLS_DEF = 16;

    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_DEL   = 8'h7F;

    localparam logic CMD_MOVE  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic ROW_TOP = 1'b0;
    localparam logic ROW_BOT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PMOVE,
        ST_PWRITE,
        ST_PNEXT,
        ST_HOME_TOP,
        ST_TOP,
        ST_HOME_BOT,
        ST_BOT,
        ST_CUR
    } state_t;

endpackage
`default_nettype wire

FILE: rtl/tlst_in_if.sv
`default_nettype none
interface tlst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;

    modport source (output valid, output char_in, input ready);
    modport sink (input valid, input char_in, output ready);
endinterface
`default_nettype wire

FILE: rtl/tlst_out_if.sv
`default_nettype none
interface tlst_out_if;
    logic       valid;
    logic       ready;
    logic       cmd_kind;
    logic [3:0] col;
    logic       row;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output cmd_kind, output col, output row,
                    output data_byte, output is_last, input ready);
    modport sink (input valid, input cmd_kind, input col, input row,
                  input data_byte, input is_last, output ready);
endinterface
`default_nettype wire

FILE: rtl/two_line_scrolling_text_terminal_core.sv
`default_nettype none
// Two-line scrolling terminal for a character display. Each accepted byte on
// char_ch yields a burst of display commands on cmd_ch (cursor moves and data
// writes), the last one flagged by is_last. CR, other control bytes and bytes
// 0x80-0xFF produce nothing. A printable byte gives 3 commands; a line feed
// gives 2*COLS+3 and a printable byte that fills the line 2*COLS+5. The
// sequencer emits one command per cycle into the output register unless the
// sink stalls; a dropped byte yields no command and leaves the block ready.
// The next byte is taken in the cycle after the last command of the current
// burst is queued. The two lines live in two memories that swap roles on a
// scroll; the new bottom line is blanked at once by its per-column valid bits,
// and the top line is read back one column per cycle during the redraw, held
// while the sink stalls.
module two_line_scrolling_text_terminal_core #(
    parameter int COLS = tlst_pkg::COLS_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tlst_in_if.sink    char_ch,
    tlst_out_if.source cmd_ch
);

    localparam int CW = $clog2(COLS);
    localparam logic [CW-1:0] LAST_COL = CW'(COLS - 1);

    // line memories; top_sel_reg names the one holding the top line
    logic [7:0]    mem0 [COLS];
    logic [7:0]    mem1 [COLS];
    logic [COLS-1:0] valid0_reg, valid0_next;
    logic [COLS-1:0] valid1_reg, valid1_next;
    logic          top_sel_reg, top_sel_next;

    tlst_pkg::state_t state_reg, state_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [CW-1:0] pcol_reg, pcol_next;
    logic [7:0]    ch_reg, ch_next;
    logic          full_reg, full_next;

    logic          out_valid_reg, out_valid_next;
    logic          cmd_kind_reg, cmd_kind_next;
    logic [3:0]    col_reg, col_next;
    logic          row_reg, row_next;
    logic [7:0]    data_reg, data_next;
    logic          last_reg, last_next;

    logic [7:0]    rd0_reg, rd1_reg;
    logic          rvalid_reg;
    logic          rd_en;
    logic [CW-1:0] rd_addr;
    logic          wr_en;

    logic          accept;
    logic          printable;
    logic          slot_free;
    logic [CW:0]   cur_inc;
    logic [7:0]    top_char;

    assign char_ch.ready = (state_reg == tlst_pkg::ST_IDLE);
    assign accept        = char_ch.valid && char_ch.ready;
    assign printable     = char_ch.char_in inside {[tlst_pkg::CHAR_SPACE:tlst_pkg::CHAR_DEL]};
    assign slot_free     = !out_valid_reg || cmd_ch.ready;
    assign cur_inc       = {1'b0, cur_reg} + (CW+1)'(1);
    assign top_char      = rvalid_reg ? (top_sel_reg ? rd1_reg : rd0_reg)
                                      : tlst_pkg::CHAR_SPACE;

    assign cmd_ch.valid     = out_valid_reg;
    assign cmd_ch.cmd_kind  = cmd_kind_reg;
    assign cmd_ch.col       = col_reg;
    assign cmd_ch.row       = row_reg;
    assign cmd_ch.data_byte = data_reg;
    assign cmd_ch.is_last   = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        cur_next       = cur_reg;
        pcol_next      = pcol_reg;
        ch_next        = ch_reg;
        full_next      = full_reg;
        top_sel_next   = top_sel_reg;
        valid0_next    = valid0_reg;
        valid1_next    = valid1_reg;
        out_valid_next = out_valid_reg;
        cmd_kind_next  = cmd_kind_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        data_next      = data_reg;
        last_next      = last_reg;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;

        if (out_valid_reg && cmd_ch.ready)
        begin
            out_valid_next = 1'b0;
        end

        if (accept && (printable || char_ch.char_in == tlst_pkg::CHAR_LF))
        begin
            // a scroll swaps the lines; the new bottom line is blanked by clearing its valid bits
            if (printable)
            begin
                wr_en     = 1'b1;
                ch_next   = char_ch.char_in;
                pcol_next = cur_reg;
                full_next = (cur_inc == (CW+1)'(COLS));
                cur_next  = full_next ? '0 : cur_inc[CW-1:0];
                if (top_sel_reg)
                begin
                    valid0_next[cur_reg] = 1'b1;
                end
                else
                begin
                    valid1_next[cur_reg] = 1'b1;
                end
                state_next = tlst_pkg::ST_PMOVE;
            end
            else
            begin
                full_next  = 1'b1;
                cur_next   = '0;
                state_next = tlst_pkg::ST_HOME_TOP;
            end
            if (full_next)
            begin
                top_sel_next = !top_sel_reg;
                if (top_sel_reg)
                begin
                    valid1_next = '0;
                end
                else
                begin
                    valid0_next = '0;
                end
            end
        end
        else if (state_reg != tlst_pkg::ST_IDLE && slot_free)
        begin
            out_valid_next = 1'b1;
            cmd_kind_next  = tlst_pkg::CMD_MOVE;
            col_next       = '0;
            row_next       = tlst_pkg::ROW_TOP;
            data_next      = '0;
            last_next      = 1'b0;
            case (state_reg)
                tlst_pkg::ST_PMOVE:
                begin
                    col_next   = 4'(pcol_reg);
                    row_next   = tlst_pkg::ROW_BOT;
                    state_next = tlst_pkg::ST_PWRITE;
                end
                tlst_pkg::ST_PWRITE:
                begin
                    cmd_kind_next = tlst_pkg::CMD_WRITE;
                    data_next     = ch_reg;
                    state_next    = full_reg ? tlst_pkg::ST_HOME_TOP : tlst_pkg::ST_PNEXT;
                end
                tlst_pkg::ST_PNEXT:
                begin
                    col_next   = 4'(cur_reg);
                    row_next   = tlst_pkg::ROW_BOT;
                    last_next  = 1'b1;
                    state_next = tlst_pkg::ST_IDLE;
                end
                tlst_pkg::ST_HOME_TOP:
                begin
                    // prefetch first top column
                    rd_en      = 1'b1;
                    rd_addr    = '0;
                    idx_next   = '0;
                    state_next = tlst_pkg::ST_TOP;
                end
                tlst_pkg::ST_TOP:
                begin
                    cmd_kind_next = tlst_pkg::CMD_WRITE;
                    data_next     = top_char;
                    rd_en         = (idx_reg != LAST_COL);
                    rd_addr       = idx_reg + CW'(1);
                    if (idx_reg == LAST_COL)
                    begin
                        idx_next   = '0;
                        state_next = tlst_pkg::ST_HOME_BOT;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                tlst_pkg::ST_HOME_BOT:
                begin
                    row_next   = tlst_pkg::ROW_BOT;
                    state_next = tlst_pkg::ST_BOT;
                end
                tlst_pkg::ST_BOT:
                begin
                    // bottom line is always blank right after a scroll
                    cmd_kind_next = tlst_pkg::CMD_WRITE;
                    data_next     = tlst_pkg::CHAR_SPACE;
                    if (idx_reg == LAST_COL)
                    begin
                        idx_next   = '0;
                        state_next = tlst_pkg::ST_CUR;
                    end
                    else
                    begin
                        idx_next = idx_reg + CW'(1);
                    end
                end
                tlst_pkg::ST_CUR:
                begin
                    col_next   = 4'(cur_reg);
                    row_next   = tlst_pkg::ROW_BOT;
                    last_next  = 1'b1;
                    state_next = tlst_pkg::ST_IDLE;
                end
                default:
                begin
                    out_valid_next = out_valid_reg;
                    state_next     = tlst_pkg::ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tlst_pkg::ST_IDLE;
            idx_reg       <= '0;
            cur_reg       <= '0;
            full_reg      <= 1'b0;
            top_sel_reg   <= 1'b0;
            valid0_reg    <= '0;
            valid1_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cur_reg       <= cur_next;
            full_reg      <= full_next;
            top_sel_reg   <= top_sel_next;
            valid0_reg    <= valid0_next;
            valid1_reg    <= valid1_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pcol_reg     <= pcol_next;
        ch_reg       <= ch_next;
        cmd_kind_reg <= cmd_kind_next;
        col_reg      <= col_next;
        row_reg      <= row_next;
        data_reg     <= data_next;
        last_reg     <= last_next;
    end

    // bottom line memory is the one not selected as top
    always_ff @(posedge clk)
    begin
        if (wr_en && top_sel_reg)
        begin
            mem0[cur_reg] <= char_ch.char_in;
        end
        if (rd_en)
        begin
            rd0_reg <= mem0[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en && !top_sel_reg)
        begin
            mem1[cur_reg] <= char_ch.char_in;
        end
        if (rd_en)
        begin
            rd1_reg <= mem1[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rvalid_reg <= 1'b0;
        end
        else if (rd_en)
        begin
            rvalid_reg <= top_sel_reg ? valid1_reg[rd_addr] : valid0_reg[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: tb/two_line_scrolling_text_terminal_core_test.sv
`timescale 1ns / 100ps

module two_line_scrolling_text_terminal_core_test;

    localparam int COLS = tlst_pkg::COLS_DEF;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam int IDLE_PCT = 36;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES = 60;
    localparam int RANDOM_CHARS = 86;

    typedef struct packed {
        logic       kind;
        logic [3:0] col;
        logic       row;
        logic [7:0] data;
        logic       last;
    } lcd_cmd_t;

    typedef struct {
        logic [7:0] ch;
        bit         drain_first;
    } char_req_t;

    logic clk = 1'b0;
    logic rst_n;

    tlst_in_if  char_ch ();
    tlst_out_if cmd_ch ();

    two_line_scrolling_text_terminal_core #(.COLS(COLS)) uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .char_ch (char_ch.sink),
        .cmd_ch  (cmd_ch.source)
    );

    always #6 clk = ~clk;

    // shadow display state
    logic [7:0] top_line [COLS];
    logic [7:0] bot_line [COLS];
    int         cur_col;

    char_req_t char_backlog [$];
    char_req_t next_req;
    lcd_cmd_t  lcd_cmds_due [$];

    int  cmds_predicted = 0;
    int  cmds_seen;
    int  chars_taken;
    int  mismatches = 0;
    int  quiet_cycles;
    int  rx_hold_left;
    bit  rx_hold_done;

    task automatic push_cmd(input logic kind, input int col, input logic row,
                            input logic [7:0] data, input logic last);
        lcd_cmd_t c;
        c.kind = kind;
        c.col  = col[3:0];
        c.row  = row;
        c.data = data;
        c.last = last;
        lcd_cmds_due.push_back(c);
        cmds_predicted++;
    endtask

    task automatic scroll_lines();
        for (int i = 0; i < COLS; i++)
        begin
            top_line[i] = bot_line[i];
            bot_line[i] = tlst_pkg::CHAR_SPACE;
        end
        cur_col = 0;
        push_cmd(tlst_pkg::CMD_MOVE, 0, tlst_pkg::ROW_TOP, '0, 1'b0);
        for (int i = 0; i < COLS; i++)
            push_cmd(tlst_pkg::CMD_WRITE, 0, 1'b0, top_line[i], 1'b0);
        push_cmd(tlst_pkg::CMD_MOVE, 0, tlst_pkg::ROW_BOT, '0, 1'b0);
        for (int i = 0; i < COLS; i++)
            push_cmd(tlst_pkg::CMD_WRITE, 0, 1'b0, bot_line[i], 1'b0);
        push_cmd(tlst_pkg::CMD_MOVE, cur_col, tlst_pkg::ROW_BOT, '0, 1'b1);
    endtask

    // CR, other control bytes and high bytes produce nothing
    task automatic predict_lcd_cmds(input logic [7:0] ch);
        if (ch == tlst_pkg::CHAR_LF)
            scroll_lines();
        else if (ch >= tlst_pkg::CHAR_SPACE && ch <= tlst_pkg::CHAR_DEL)
        begin
            bot_line[cur_col] = ch;
            push_cmd(tlst_pkg::CMD_MOVE, cur_col, tlst_pkg::ROW_BOT, '0, 1'b0);
            push_cmd(tlst_pkg::CMD_WRITE, 0, 1'b0, ch, 1'b0);
            cur_col++;
            if (cur_col >= COLS)
                scroll_lines();
            else
                push_cmd(tlst_pkg::CMD_MOVE, cur_col, tlst_pkg::ROW_BOT, '0, 1'b1);
        end
    endtask

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            char_ch.valid   <= 1'b0;
            char_ch.char_in <= '0;
            chars_taken     <= 0;
        end
        else
        begin
            if (char_ch.valid && char_ch.ready)
            begin
                predict_lcd_cmds(char_ch.char_in);
                chars_taken <= chars_taken + 1;
            end
            if (!char_ch.valid || char_ch.ready)
            begin
                if (char_backlog.size() != 0
                    && !(char_backlog[0].drain_first && cmds_predicted != cmds_seen)
                    && ((chars_taken >= 70 && chars_taken < 100)
                        || $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    next_req = char_backlog.pop_front();
                    char_ch.valid   <= 1'b1;
                    char_ch.char_in <= next_req.ch;
                end
                else
                    char_ch.valid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off once the random part is under way
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.ready <= 1'b0;
            rx_hold_left <= 0;
            rx_hold_done <= 1'b0;
        end
        else if (chars_taken >= 40 && !rx_hold_done)
        begin
            rx_hold_done <= 1'b1;
            rx_hold_left <= RX_HOLD_CYCLES;
            cmd_ch.ready <= 1'b0;
        end
        else if (rx_hold_left != 0)
        begin
            rx_hold_left <= rx_hold_left - 1;
            cmd_ch.ready <= 1'b0;
        end
        else
            cmd_ch.ready <= (cmds_seen >= 400 && cmds_seen < 700)
                            || $urandom_range(0, 99) >= IDLE_PCT;
    end

    // command checker
    always @(posedge clk or negedge rst_n)
    begin
        lcd_cmd_t got;
        lcd_cmd_t want;
        if (!rst_n)
            cmds_seen <= 0;
        else if (cmd_ch.valid && cmd_ch.ready)
        begin
            cmds_seen <= cmds_seen + 1;
            got = {cmd_ch.cmd_kind, cmd_ch.col, cmd_ch.row, cmd_ch.data_byte,
                   cmd_ch.is_last};
            if (lcd_cmds_due.size() == 0)
            begin
                if (mismatches < 10)
                    $display("unexpected cmd kind=%0d col=%0d row=%0d data=%h last=%0d",
                             got.kind, got.col, got.row, got.data, got.last);
                mismatches++;
            end
            else
            begin
                want = lcd_cmds_due.pop_front();
                if (got.kind !== want.kind || got.col !== want.col
                    || got.row !== want.row || got.data !== want.data
                    || got.last !== want.last)
                begin
                    if (mismatches < 10)
                    begin
                        $display("cmd %0d: exp kind=%0d col=%0d row=%0d data=%h last=%0d",
                                 cmds_seen, want.kind, want.col, want.row, want.data,
                                 want.last);
                        $display("cmd %0d: got kind=%0d col=%0d row=%0d data=%h last=%0d",
                                 cmds_seen, got.kind, got.col, got.row, got.data,
                                 got.last);
                    end
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge clk)
    begin
        if ((char_ch.valid && char_ch.ready) || (cmd_ch.valid && cmd_ch.ready) || !rst_n)
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("two_line_scrolling_text_terminal_core regression: fail");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic queue_char(input logic [7:0] ch, input bit drain_first);
        char_req_t r;
        r.ch = ch;
        r.drain_first = drain_first;
        char_backlog.push_back(r);
    endtask

    initial
    begin
        int made;
        int pick;
        logic [7:0] ch;

        for (int i = 0; i < COLS; i++)
        begin
            top_line[i] = tlst_pkg::CHAR_SPACE;
            bot_line[i] = tlst_pkg::CHAR_SPACE;
        end
        cur_col = 0;

        // directed: printable, the dropped classes, LF over a non-empty line,
        // then a full line including space and DEL, then LF over an empty line
        queue_char(8'h41, 1'b0);
        queue_char(CHAR_CR, 1'b0);
        queue_char(8'h00, 1'b0);
        queue_char(8'h1F, 1'b0);
        queue_char(8'h80, 1'b0);
        queue_char(8'hFF, 1'b0);
        queue_char(tlst_pkg::CHAR_LF, 1'b0);
        queue_char(tlst_pkg::CHAR_SPACE, 1'b0);
        for (int i = 0; i < COLS - 2; i++)
            queue_char(8'(8'h61 + i), 1'b0);
        queue_char(tlst_pkg::CHAR_DEL, 1'b0);
        queue_char(tlst_pkg::CHAR_LF, 1'b0);

        made = 0;
        while (made < RANDOM_CHARS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 70)
                ch = 8'($urandom_range(tlst_pkg::CHAR_SPACE, tlst_pkg::CHAR_DEL));
            else if (pick < 82)
                ch = tlst_pkg::CHAR_LF;
            else if (pick < 88)
                ch = CHAR_CR;
            else if (pick < 94)
                ch = 8'($urandom_range(0, 31));
            else
                ch = 8'($urandom_range(128, 255));
            // sender waits for the block to drain before the first random
            // request and once more midway
            queue_char(ch, made == 0 || made == 60);
            made++;
        end

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (char_backlog.size() != 0 || char_ch.valid)
            @(posedge clk);
        while (cmds_seen != cmds_predicted)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && lcd_cmds_due.size() == 0)
            $display("two_line_scrolling_text_terminal_core regression: pass");
        else
            $display("two_line_scrolling_text_terminal_core regression: fail");
        $finish;
    end

endmodule

FILE: sim.f
rtl/tlst_pkg.sv
rtl/tlst_in_if.sv
rtl/tlst_out_if.sv
rtl/two_line_scrolling_text_terminal_core.sv
tb/two_line_scrolling_text_terminal_core_test.sv
